FILE: src/two_button_debounce_repeat_adjust_top_macros.svh
// Assertion macros shared by the checker of the two-button rate adjuster.
`ifndef TWO_BUTTON_DEBOUNCE_REPEAT_ADJUST_TOP_MACROS_SVH
`define TWO_BUTTON_DEBOUNCE_REPEAT_ADJUST_TOP_MACROS_SVH

// Same-cycle implication on clk, checked only while rst_n is high.
`define TBDRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on clk, checked only while rst_n is high.
`define TBDRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tbdra_pkg.sv
// Types and constants shared by the two-button rate adjuster.
package tbdra_pkg;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_DEC   = 2'd1,
        ACT_INC   = 2'd2,
        ACT_COMBO = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_STEP_SIZE       = 3'd0,
        REG_DEBOUNCE_TIME   = 3'd1,
        REG_HOLD_DELAY      = 3'd2,
        REG_REPEAT_INTERVAL = 3'd3,
        REG_COMBO_TIME      = 3'd4,
        REG_RATE_MIN        = 3'd5,
        REG_RATE_MAX        = 3'd6,
        REG_RATE_DEFAULT    = 3'd7
    } reg_idx_t;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [4:0]  STEP_SIZE_RST       = 5'd1;
    localparam logic [9:0]  DEBOUNCE_TIME_RST   = 10'd25;
    localparam logic [13:0] HOLD_DELAY_RST      = 14'd600;
    localparam logic [13:0] REPEAT_INTERVAL_RST = 14'd120;
    localparam logic [9:0]  COMBO_TIME_RST      = 10'd80;
    localparam logic [7:0]  RATE_MIN_RST        = 8'd30;
    localparam logic [7:0]  RATE_MAX_RST        = 8'd220;
    localparam logic [7:0]  RATE_DEFAULT_RST    = 8'd90;

    typedef struct packed {
        logic down_pressed;
        logic up_pressed;
    } in_item_t;

    typedef struct packed {
        logic [7:0] rate_value;
        action_t    action;
        logic       rate_changed;
    } out_item_t;

    typedef struct packed {
        logic [4:0]  step_size;
        logic [9:0]  debounce_time;
        logic [13:0] hold_delay;
        logic [13:0] repeat_interval;
        logic [9:0]  combo_time;
        logic [7:0]  rate_min;
        logic [7:0]  rate_max;
        logic [7:0]  rate_default;
    } cfg_t;

    // What one button lane reports to the merge stage for the current tick.
    typedef struct packed {
        logic stable;
        logic want;
    } lane_status_t;

endpackage

FILE: src/tbdra_lane.sv
// One button lane: debounce, press timing and auto-repeat request.
module tbdra_lane #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    level,
    input  logic [9:0]              debounce_time,
    input  logic [13:0]             hold_delay,
    input  logic [13:0]             repeat_interval,
    input  logic                    clear_repeat,
    output tbdra_pkg::lane_status_t status
);
    import tbdra_pkg::*;

    localparam int CmpW = (TIMER_WIDTH > 14) ? TIMER_WIDTH : 14;
    localparam logic [TIMER_WIDTH-1:0] TMax = '1;

    logic                   raw_reg, raw_next;
    logic                   stable_reg, stable_next;
    logic [TIMER_WIDTH-1:0] rce_reg, rce_next;
    logic [TIMER_WIDTH-1:0] pe_reg, pe_next;
    logic [TIMER_WIDTH-1:0] re_reg, re_next;
    logic [TIMER_WIDTH-1:0] re_sampled;
    logic                   settle, press, edge_hit, rep_hit;

    function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
        return (v == TMax) ? v : v + 1'b1;
    endfunction

    always_comb
    begin
        raw_next    = level;
        rce_next    = (level != raw_reg) ? '0 : sat_inc(rce_reg);
        settle      = (stable_reg != raw_next) &&
                      (CmpW'(rce_next) >= CmpW'(debounce_time));
        stable_next = settle ? raw_next : stable_reg;
        press       = settle && raw_next;
        pe_next     = press ? '0 : sat_inc(pe_reg);
        re_sampled  = press ? '0 : sat_inc(re_reg);
        edge_hit    = stable_next && !stable_reg;
        rep_hit     = stable_next && (CmpW'(pe_next) >= CmpW'(hold_delay)) &&
                      (CmpW'(re_sampled) >= CmpW'(repeat_interval));
        re_next     = clear_repeat ? '0 : re_sampled;
        status.stable = stable_next;
        status.want   = edge_hit || rep_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg    <= 1'b0;
            stable_reg <= 1'b0;
            rce_reg    <= '0;
            pe_reg     <= '0;
            re_reg     <= '0;
        end
        else if (advance)
        begin
            raw_reg    <= raw_next;
            stable_reg <= stable_next;
            rce_reg    <= rce_next;
            pe_reg     <= pe_next;
            re_reg     <= re_next;
        end
    end

endmodule

FILE: src/tbdra_merge.sv
// Merge stage: combo detection and the clamped rate update.
module tbdra_merge #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  tbdra_pkg::cfg_t         cfg,
    input  tbdra_pkg::lane_status_t down_status,
    input  tbdra_pkg::lane_status_t up_status,
    output logic [1:0]              clear_repeat,
    output tbdra_pkg::out_item_t    result
);
    import tbdra_pkg::*;

    localparam int CmpW = (TIMER_WIDTH > 10) ? TIMER_WIDTH : 10;
    localparam logic [TIMER_WIDTH-1:0] TMax = '1;

    logic                   running_reg, running_next;
    logic                   done_reg, done_next;
    logic [TIMER_WIDTH-1:0] ce_reg, ce_next;
    logic [7:0]             rate_reg, rate_next;
    logic [7:0]             rate_after_dec;
    logic signed [9:0]      dec_val, inc_val;
    logic                   both, fire;
    action_t                act;

    function automatic logic [7:0] clamp(input logic signed [9:0] v,
                                         input logic [7:0] lo, input logic [7:0] hi);
        logic [7:0] r;
        if (v < signed'({2'b00, lo}))
            r = lo;
        else if (v > signed'({2'b00, hi}))
            r = hi;
        else
            r = v[7:0];
        return r;
    endfunction

    always_comb
    begin
        both           = down_status.stable && up_status.stable;
        dec_val        = signed'({2'b00, rate_reg}) - signed'({5'b00000, cfg.step_size});
        rate_after_dec = down_status.want ? clamp(dec_val, cfg.rate_min, cfg.rate_max)
                                          : rate_reg;
        inc_val        = signed'({2'b00, rate_after_dec}) +
                         signed'({5'b00000, cfg.step_size});
        running_next   = 1'b0;
        ce_next        = '0;
        done_next      = 1'b0;
        fire           = 1'b0;
        clear_repeat   = 2'b00;
        rate_next      = rate_reg;
        act            = ACT_NONE;
        if (both)
        begin
            running_next = 1'b1;
            ce_next      = !running_reg ? '0 : ((ce_reg == TMax) ? ce_reg : ce_reg + 1'b1);
            fire         = !done_reg && (CmpW'(ce_next) >= CmpW'(cfg.combo_time));
            done_next    = done_reg || fire;
            if (fire)
            begin
                rate_next = clamp(signed'({2'b00, cfg.rate_default}),
                                  cfg.rate_min, cfg.rate_max);
                act       = ACT_COMBO;
            end
        end
        else
        begin
            clear_repeat = {up_status.want, down_status.want};
            rate_next    = up_status.want ? clamp(inc_val, cfg.rate_min, cfg.rate_max)
                                          : rate_after_dec;
            if (up_status.want)
                act = ACT_INC;
            else if (down_status.want)
                act = ACT_DEC;
        end
        result.rate_value   = rate_next;
        result.action       = act;
        result.rate_changed = (rate_next != rate_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            ce_reg      <= '0;
            rate_reg    <= RATE_DEFAULT_RST;
        end
        else if (advance)
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            ce_reg      <= ce_next;
            rate_reg    <= rate_next;
        end
    end

endmodule

FILE: src/two_button_debounce_repeat_adjust_top.sv
// Top level of the two-button rate adjuster: config port, lanes, merge, output skid.
// A tick request accepted at an edge has its result registered into the output register,
// or into the skid entry while a waiting result is held by the consumer.
// Throughput: one tick request per cycle while the skid entry is empty.
// The two-entry output stage (result register plus skid) still accepts a tick while one result waits.
// Reset (rst_n low, asynchronous): buttons released, all timers zero, rate 90, registers
// back to their defaults, no result pending.
module two_button_debounce_repeat_adjust_top #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // tick request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  tbdra_pkg::in_item_t             in_data,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output tbdra_pkg::out_item_t            out_data,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tbdra_pkg::ADDR_W-1:0]    paddr,
    input  logic [tbdra_pkg::DATA_W-1:0]    pwdata,
    output logic [tbdra_pkg::DATA_W-1:0]    prdata,
    output logic                            pready
);
    import tbdra_pkg::*;

    // ------------------------------------------------------------------
    // Register file. Registers sit at byte address 4*index; the word
    // index is paddr[4:2]. Writes land on the access phase.
    // ------------------------------------------------------------------
    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size       <= STEP_SIZE_RST;
            cfg_reg.debounce_time   <= DEBOUNCE_TIME_RST;
            cfg_reg.hold_delay      <= HOLD_DELAY_RST;
            cfg_reg.repeat_interval <= REPEAT_INTERVAL_RST;
            cfg_reg.combo_time      <= COMBO_TIME_RST;
            cfg_reg.rate_min        <= RATE_MIN_RST;
            cfg_reg.rate_max        <= RATE_MAX_RST;
            cfg_reg.rate_default    <= RATE_DEFAULT_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_STEP_SIZE:       cfg_reg.step_size       <= pwdata[4:0];
                REG_DEBOUNCE_TIME:   cfg_reg.debounce_time   <= pwdata[9:0];
                REG_HOLD_DELAY:      cfg_reg.hold_delay      <= pwdata[13:0];
                REG_REPEAT_INTERVAL: cfg_reg.repeat_interval <= pwdata[13:0];
                REG_COMBO_TIME:      cfg_reg.combo_time      <= pwdata[9:0];
                REG_RATE_MIN:        cfg_reg.rate_min        <= pwdata[7:0];
                REG_RATE_MAX:        cfg_reg.rate_max        <= pwdata[7:0];
                REG_RATE_DEFAULT:    cfg_reg.rate_default    <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb
    begin
        case (reg_idx)
            REG_STEP_SIZE:       prdata = DATA_W'(cfg_reg.step_size);
            REG_DEBOUNCE_TIME:   prdata = DATA_W'(cfg_reg.debounce_time);
            REG_HOLD_DELAY:      prdata = DATA_W'(cfg_reg.hold_delay);
            REG_REPEAT_INTERVAL: prdata = DATA_W'(cfg_reg.repeat_interval);
            REG_COMBO_TIME:      prdata = DATA_W'(cfg_reg.combo_time);
            REG_RATE_MIN:        prdata = DATA_W'(cfg_reg.rate_min);
            REG_RATE_MAX:        prdata = DATA_W'(cfg_reg.rate_max);
            REG_RATE_DEFAULT:    prdata = DATA_W'(cfg_reg.rate_default);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake. The block stalls input only while the skid entry is
    // full, so a waiting result never blocks the next tick by itself.
    // ------------------------------------------------------------------
    logic      out_valid_reg;
    logic      skid_valid_reg;
    out_item_t out_data_reg;
    out_item_t skid_data_reg;
    logic      in_fire, out_fire;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Lanes: lane 0 watches the down button, lane 1 the up button. Each
    // advances its debounce and press timers only on an accepted tick.
    // ------------------------------------------------------------------
    logic [1:0]   level;
    logic [1:0]   clear_repeat;
    lane_status_t lane_status [2];
    out_item_t    result;

    assign level = {in_data.up_pressed, in_data.down_pressed};

    for (genvar b = 0; b < 2; b++)
    begin : g_lane
        tbdra_lane #(
            .TIMER_WIDTH (TIMER_WIDTH)
        ) u_lane (
            .clk             (clk),
            .rst_n           (rst_n),
            .advance         (in_fire),
            .level           (level[b]),
            .debounce_time   (cfg_reg.debounce_time),
            .hold_delay      (cfg_reg.hold_delay),
            .repeat_interval (cfg_reg.repeat_interval),
            .clear_repeat    (clear_repeat[b]),
            .status          (lane_status[b])
        );
    end

    // Merge: combo reset wins over single-button steps; down applies
    // before up when both lanes request a step on the same tick.
    tbdra_merge #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (in_fire),
        .cfg          (cfg_reg),
        .down_status  (lane_status[0]),
        .up_status    (lane_status[1]),
        .clear_repeat (clear_repeat),
        .result       (result)
    );

    // ------------------------------------------------------------------
    // Output register plus skid. Drain the skid first; otherwise load a
    // fresh result into the output register when it frees up, or park
    // it in the skid when the consumer is stalling.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_data_reg <= skid_data_reg;
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
                skid_data_reg <= result;
            else
                out_data_reg <= result;
        end
    end

endmodule

FILE: src/tbdra_checker.sv
// Port-level checker for the two-button rate adjuster, bound to the top level.
`include "two_button_debounce_repeat_adjust_top_macros.svh"

module tbdra_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input tbdra_pkg::out_item_t            out_data
);
    import tbdra_pkg::*;

    logic out_wait;
    logic in_take;
    logic quiet_out;

    assign out_wait  = out_valid && out_stall;
    assign in_take   = in_valid && !in_stall;
    assign quiet_out = out_valid && (out_data.action == ACT_NONE);

    // A stalled result holds.
    `TBDRA_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_data), "held result moved")

    // With nothing pending on the output the block must take a request.
    `TBDRA_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall, "stall with empty output")

    // After every accepted request, out_valid is high in the next cycle.
    `TBDRA_ASSERT_NEXT(a_result_follows, in_take, out_valid, "request without result")

    // The rate only moves on a step or a combo reset.
    `TBDRA_ASSERT_NOW(a_quiet_tick, quiet_out, !out_data.rate_changed, "rate moved without action")

endmodule

bind two_button_debounce_repeat_adjust_top tbdra_checker u_tbdra_checker (.*);
